// ----- design/ptc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants of the PID torque controller
// Item structs, configuration register indexes, sequencer control codes and
// fixed-point widths used by the controller and its sub-blocks.
// ----------------------------------------------------------------------------
package ptc_pkg;

  localparam int unsigned DATA_W  = 32;            // Q16.16 samples and gains
  localparam int unsigned INTEG_W = 48;            // Q32.16 integrator
  localparam int unsigned MUL_W   = DATA_W + 1;    // signed operand width
  localparam int unsigned PROD_W  = 2 * MUL_W;     // full product width
  localparam int unsigned ACC_W   = PROD_W + 16;   // holds ki * I exactly
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [DATA_W-1:0]  HALF_PERIOD_RST = 32'd1073742;
  localparam logic [DATA_W-1:0]  DRIVE_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0]  DRIVE_MIN = 32'h8000_0000;
  localparam logic [INTEG_W-1:0] INTEG_MAX = 48'h7FFF_FFFF_FFFF;
  localparam logic [INTEG_W-1:0] INTEG_MIN = 48'h8000_0000_0000;

  typedef struct packed {
    logic signed [DATA_W-1:0] torque_ref;
    logic signed [DATA_W-1:0] torque_meas;
    logic signed [DATA_W-1:0] rate_ref;
    logic signed [DATA_W-1:0] rate_meas;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] drive;
    logic                     clipped;
  } out_item_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN   = 2'd0,
    CFG_INTEG_GAIN  = 2'd1,
    CFG_DERIV_GAIN  = 2'd2,
    CFG_HALF_PERIOD = 2'd3
  } cfg_idx_e;

  // Operand pair fed to the shared multiplier
  typedef enum logic [2:0] {
    MUL_INC  = 3'd0,   // half_period * (e + last error)
    MUL_PROP = 3'd1,   // kp * e
    MUL_DERV = 3'd2,   // kd * edot
    MUL_IHI  = 3'd3,   // ki * integer part of integrator
    MUL_ILO  = 3'd4    // ki * fraction of integrator
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD   = 2'd0,
    ACC_LOAD   = 2'd1,
    ACC_ADD    = 2'd2,
    ACC_ADD_SH = 2'd3   // add product shifted up by 16
  } acc_op_e;

  typedef struct packed {
    logic     in_ready;
    logic     load_err;
    logic     integ_upd;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     out_load;
  } ctrl_t;

endpackage

// ----- design/ptc_mul.sv -----
// ----------------------------------------------------------------------------
// ptc_mul: shared signed multiplier
// One 33 x 33 signed multiply per cycle with the full product registered.
// ----------------------------------------------------------------------------
module ptc_mul (
  input  logic                                 clk_i,
  input  logic signed [ptc_pkg::MUL_W-1:0]     a_i,
  input  logic signed [ptc_pkg::MUL_W-1:0]     b_i,
  output logic signed [ptc_pkg::PROD_W-1:0]    prod_o
);

  logic signed [ptc_pkg::PROD_W-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule

// ----- design/ptc_seq.sv -----
// ----------------------------------------------------------------------------
// ptc_seq: step sequencer of the PID torque controller
// Walks one item through the five multiplies, integrator update,
// accumulation and output load.
// ----------------------------------------------------------------------------
module ptc_seq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           out_free_i,
  output ptc_pkg::ctrl_t ctrl_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_INC  = 8'b0000_0010,
    S_PROP = 8'b0000_0100,
    S_DERV = 8'b0000_1000,
    S_IHI  = 8'b0001_0000,
    S_ILO  = 8'b0010_0000,
    S_SUM  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d          = state_q;
    ctrl_o           = '0;
    ctrl_o.mul_sel   = ptc_pkg::MUL_INC;
    ctrl_o.acc_op    = ptc_pkg::ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.in_ready = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load_err = 1'b1;
          state_d         = S_INC;
        end
      end
      S_INC: begin
        ctrl_o.mul_sel = ptc_pkg::MUL_INC;
        state_d        = S_PROP;
      end
      S_PROP: begin
        ctrl_o.integ_upd = 1'b1;
        ctrl_o.mul_sel   = ptc_pkg::MUL_PROP;
        state_d          = S_DERV;
      end
      S_DERV: begin
        ctrl_o.acc_op  = ptc_pkg::ACC_LOAD;
        ctrl_o.mul_sel = ptc_pkg::MUL_DERV;
        state_d        = S_IHI;
      end
      S_IHI: begin
        ctrl_o.acc_op  = ptc_pkg::ACC_ADD;
        ctrl_o.mul_sel = ptc_pkg::MUL_IHI;
        state_d        = S_ILO;
      end
      S_ILO: begin
        ctrl_o.acc_op  = ptc_pkg::ACC_ADD_SH;
        ctrl_o.mul_sel = ptc_pkg::MUL_ILO;
        state_d        = S_SUM;
      end
      S_SUM: begin
        ctrl_o.acc_op = ptc_pkg::ACC_ADD;
        state_d       = S_DONE;
      end
      S_DONE: begin
        // hold until the output register is free
        if (out_free_i) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/pid_trapezoid_controller_top.sv -----
// ----------------------------------------------------------------------------
// pid_trapezoid_controller_top: discrete PID controller, trapezoidal integral
// Per control sample: saturated error and error rate, trapezoid integrator
// update and the saturated sum kp*e + ki*I + kd*edot in Q16.16.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_item_i) takes one sample item
//   holding torque_ref, torque_meas, rate_ref and rate_meas.
//   Output channel (out_valid_o / out_ready_i / out_item_o) returns drive and
//   the clipped flag, one result item per sample item.
//   Configuration channel (cfg_valid_i / cfg_ready_o / cfg_index_i /
//   cfg_data_i) writes prop_gain, integ_gain, deriv_gain, half_period and is
//   always ready; the user writes it only while no item is in flight, which
//   the block itself does not enforce. An accepted item holds the input off
//   until its result is loaded into the output register; this is set by the
//   single 33 x 33 multiplier, which forms five products in turn, plus the
//   integrator, rounding and output steps.
//   Reset clears the gains, the integrator and the stored error and loads
//   half_period with its default of about 0.00025.
//   If the receiver stalls, the finished result waits in the output register
//   and the next item is still accepted and worked; that one then holds in
//   its last step until the output register empties.
// ----------------------------------------------------------------------------
module pid_trapezoid_controller_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  ptc_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output ptc_pkg::out_item_t                 out_item_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ptc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ptc_pkg::DATA_W-1:0]         cfg_data_i
);

  localparam int unsigned DW  = ptc_pkg::DATA_W;
  localparam int unsigned IW  = ptc_pkg::INTEG_W;
  localparam int unsigned MW  = ptc_pkg::MUL_W;
  localparam int unsigned PW  = ptc_pkg::PROD_W;
  localparam int unsigned AW  = ptc_pkg::ACC_W;
  localparam int unsigned INCW = PW - DW;           // rounded increment width

  // configuration registers
  logic [DW-1:0] kp_q, ki_q, kd_q, half_q;
  // controller state
  logic [IW-1:0] integ_q;
  logic [DW-1:0] last_q;
  // per item working registers
  logic [DW-1:0] e_q, ed_q;
  logic [AW-1:0] acc_q, acc_d;
  logic          clip_q;
  ptc_pkg::out_item_t out_q;
  logic          out_valid_q;

  ptc_pkg::ctrl_t ctrl;
  logic           out_free;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;

  logic [DW:0]   diff_e, diff_ed;
  logic [DW-1:0] e_sat, ed_sat;
  logic [MW-1:0] err_sum;
  logic [PW-1:0] inc_rnd;
  logic [INCW-1:0] inc;
  logic [IW+1:0] integ_sum;
  logic [IW-1:0] integ_new;
  logic          integ_hit;
  logic [AW-1:0] out_rnd;
  logic [AW-17:0] drive_full;
  logic [DW-1:0] drive_sat;
  logic          drive_hit;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  ptc_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .out_free_i (out_free),
    .ctrl_o     (ctrl)
  );

  assign in_ready_o = ctrl.in_ready;

  // Error and error rate, saturated to Q16.16
  always_comb begin
    diff_e  = {in_item_i.torque_ref[DW-1], in_item_i.torque_ref}
            - {in_item_i.torque_meas[DW-1], in_item_i.torque_meas};
    diff_ed = {in_item_i.rate_ref[DW-1], in_item_i.rate_ref}
            - {in_item_i.rate_meas[DW-1], in_item_i.rate_meas};
    if (diff_e[DW] != diff_e[DW-1]) begin
      e_sat = diff_e[DW] ? ptc_pkg::DRIVE_MIN : ptc_pkg::DRIVE_MAX;
    end else begin
      e_sat = diff_e[DW-1:0];
    end
    if (diff_ed[DW] != diff_ed[DW-1]) begin
      ed_sat = diff_ed[DW] ? ptc_pkg::DRIVE_MIN : ptc_pkg::DRIVE_MAX;
    end else begin
      ed_sat = diff_ed[DW-1:0];
    end
  end

  assign err_sum = {e_q[DW-1], e_q} + {last_q[DW-1], last_q};

  // Operand selection for the shared multiplier
  always_comb begin
    case (ctrl.mul_sel)
      ptc_pkg::MUL_INC: begin
        mul_a = {1'b0, half_q};
        mul_b = err_sum;
      end
      ptc_pkg::MUL_PROP: begin
        mul_a = {kp_q[DW-1], kp_q};
        mul_b = {e_q[DW-1], e_q};
      end
      ptc_pkg::MUL_DERV: begin
        mul_a = {kd_q[DW-1], kd_q};
        mul_b = {ed_q[DW-1], ed_q};
      end
      ptc_pkg::MUL_IHI: begin
        mul_a = {ki_q[DW-1], ki_q};
        mul_b = {integ_q[IW-1], integ_q[IW-1:16]};
      end
      ptc_pkg::MUL_ILO: begin
        mul_a = {ki_q[DW-1], ki_q};
        mul_b = {{(MW-16){1'b0}}, integ_q[15:0]};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  ptc_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  // Trapezoid increment: round half up from Q.48 to Q.16, then saturate
  always_comb begin
    inc_rnd   = prod + PW'(64'h8000_0000);
    inc       = inc_rnd[PW-1:DW];
    integ_sum = {{2{integ_q[IW-1]}}, integ_q} + {{(IW+2-INCW){inc[INCW-1]}}, inc};
    integ_hit = !((integ_sum[IW+1:IW-1] == 3'b000) || (integ_sum[IW+1:IW-1] == 3'b111));
    if (integ_hit) begin
      integ_new = integ_sum[IW+1] ? ptc_pkg::INTEG_MIN : ptc_pkg::INTEG_MAX;
    end else begin
      integ_new = integ_sum[IW-1:0];
    end
  end

  // Accumulate the products of the output sum
  always_comb begin
    case (ctrl.acc_op)
      ptc_pkg::ACC_LOAD:   acc_d = {{(AW-PW){prod[PW-1]}}, prod};
      ptc_pkg::ACC_ADD:    acc_d = acc_q + {{(AW-PW){prod[PW-1]}}, prod};
      ptc_pkg::ACC_ADD_SH: acc_d = acc_q + {prod, 16'b0};
      default:             acc_d = acc_q;
    endcase
  end

  // Round half up to Q16.16 and clamp
  always_comb begin
    out_rnd    = acc_q + AW'(32'h0000_8000);
    drive_full = out_rnd[AW-1:16];
    drive_hit  = !((&drive_full[AW-17:DW-1]) || !(|drive_full[AW-17:DW-1]));
    if (drive_hit) begin
      drive_sat = drive_full[AW-17] ? ptc_pkg::DRIVE_MIN : ptc_pkg::DRIVE_MAX;
    end else begin
      drive_sat = drive_full[DW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      half_q <= ptc_pkg::HALF_PERIOD_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (ptc_pkg::cfg_idx_e'(cfg_index_i))
        ptc_pkg::CFG_PROP_GAIN:   kp_q   <= cfg_data_i;
        ptc_pkg::CFG_INTEG_GAIN:  ki_q   <= cfg_data_i;
        ptc_pkg::CFG_DERIV_GAIN:  kd_q   <= cfg_data_i;
        ptc_pkg::CFG_HALF_PERIOD: half_q <= cfg_data_i;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q     <= '0;
      last_q      <= '0;
      clip_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctrl.integ_upd) begin
        integ_q <= integ_new;
        last_q  <= e_q;
        clip_q  <= integ_hit;
      end
      if (ctrl.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.load_err) begin
      e_q  <= e_sat;
      ed_q <= ed_sat;
    end
    acc_q <= acc_d;
    if (ctrl.out_load) begin
      out_q.drive   <= drive_sat;
      out_q.clipped <= clip_q || drive_hit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // An accepted item blocks the input until its result is loaded
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input accepted twice without finishing an item");

  // A result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.out_load |-> out_free)
    else $error("result loaded while output register occupied");

  // Integrator clip flag only with the integrator on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(ctrl.integ_upd) && clip_q |->
      (integ_q == ptc_pkg::INTEG_MAX) || (integ_q == ptc_pkg::INTEG_MIN))
    else $error("integrator clip flagged off the rail");

endmodule

// ----- bench/pid_trapezoid_controller_top_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pid_trapezoid_controller_top_test: self-checking bench for the PID controller
// Drives control samples and register writes through the valid/ready channels,
// predicts drive and the clipped flag from the saturated error, error rate and
// trapezoid integrator, and compares every result in order. Covers directed
// corner cases, random mixes under sender gaps and receiver stalls, and a
// full-scale wind-up run of the integrator in both directions.
// ----------------------------------------------------------------------------
module pid_trapezoid_controller_top_test;

  typedef enum int unsigned {
    SPAN_SMALL,
    SPAN_FULL,
    SPAN_EXTREME
  } value_span_e;

  localparam logic signed [95:0] Q16_MAX   = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] Q16_MIN   = -96'sh8000_0000;
  localparam logic signed [95:0] INTEG_HI  = 96'sh7FFF_FFFF_FFFF;
  localparam logic signed [95:0] INTEG_LO  = -96'sh8000_0000_0000;
  localparam int unsigned        MAX_PRINT = 40;

  logic                       clk = 1'b0;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  ptc_pkg::in_item_t          in_item = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  ptc_pkg::out_item_t         out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  ptc_pkg::cfg_idx_e          cfg_index = ptc_pkg::CFG_PROP_GAIN;
  logic [ptc_pkg::DATA_W-1:0] cfg_data = '0;

  // controller state as predicted by the bench
  logic signed [95:0] kp_gain = '0;
  logic signed [95:0] ki_gain = '0;
  logic signed [95:0] kd_gain = '0;
  logic [31:0]        half_period_q = ptc_pkg::HALF_PERIOD_RST;
  logic signed [95:0] integ_acc = '0;
  logic signed [95:0] prev_error = '0;

  ptc_pkg::out_item_t expected_drive_q[$];
  ptc_pkg::out_item_t oldest_expected;
  int unsigned mismatches = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned settings_count = 0;

  logic        stall_enable = 1'b0;
  logic [15:0] stall_pattern = 16'hFFFF;
  logic [3:0]  stall_phase = '0;

  pid_trapezoid_controller_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [95:0] clamp_to(input logic signed [95:0] v,
                                                  input logic signed [95:0] lo,
                                                  input logic signed [95:0] hi,
                                                  output logic hit);
    hit = 1'b0;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // Advance the controller by one sample and return the drive it produces
  function automatic ptc_pkg::out_item_t step_controller(input ptc_pkg::in_item_t s);
    logic signed [95:0] err, err_rate, incr, next_i, sum, rounded;
    logic               hit_e, hit_i, hit_o;
    ptc_pkg::out_item_t r;
    err      = clamp_to(96'($signed(s.torque_ref)) - 96'($signed(s.torque_meas)),
                        Q16_MIN, Q16_MAX, hit_e);
    err_rate = clamp_to(96'($signed(s.rate_ref)) - 96'($signed(s.rate_meas)),
                        Q16_MIN, Q16_MAX, hit_e);
    // trapezoid step, rounded to nearest with ties upward
    incr   = ($signed({64'd0, half_period_q}) * (err + prev_error)
              + 96'sh8000_0000) >>> 32;
    next_i = clamp_to(integ_acc + incr, INTEG_LO, INTEG_HI, hit_i);
    integ_acc  = next_i;
    prev_error = err;
    sum     = kp_gain * err + ki_gain * integ_acc + kd_gain * err_rate;
    rounded = clamp_to((sum + 96'sh8000) >>> 16, Q16_MIN, Q16_MAX, hit_o);
    r.drive   = rounded[31:0];
    r.clipped = hit_i | hit_o;
    return r;
  endfunction

  function automatic logic [31:0] rand_word(input value_span_e span);
    logic [31:0] w;
    case (span)
      SPAN_SMALL: begin
        w = $urandom_range(0, 32'h0020_0000);
        w = w - 32'h0010_0000;
      end
      SPAN_FULL: w = $urandom;
      default: begin
        case ($urandom_range(0, 4))
          0: w = 32'h7FFF_FFFF;
          1: w = 32'h8000_0000;
          2: w = 32'h0000_0000;
          3: w = 32'hFFFF_FFFF;
          default: w = 32'h0001_0000;
        endcase
      end
    endcase
    return w;
  endfunction

  function automatic value_span_e rand_span();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 7) return SPAN_SMALL;
    if (roll < 9) return SPAN_FULL;
    return SPAN_EXTREME;
  endfunction

  function automatic ptc_pkg::in_item_t make_sample(input logic [31:0] r, m, dr, dm);
    ptc_pkg::in_item_t s;
    s.torque_ref  = r;
    s.torque_meas = m;
    s.rate_ref    = dr;
    s.rate_meas   = dm;
    return s;
  endfunction

  function automatic ptc_pkg::in_item_t random_sample();
    return make_sample(rand_word(rand_span()), rand_word(rand_span()),
                       rand_word(rand_span()), rand_word(rand_span()));
  endfunction

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINT)
      $display("MISMATCH @%0t: %s", $time, what);
  endtask

  // Leaves valid high on return so a following item goes out back to back
  task automatic send_sample(input ptc_pkg::in_item_t s);
    in_valid <= 1'b1;
    in_item  <= s;
    do @(posedge clk); while (!in_ready);
    expected_drive_q.push_back(step_controller(s));
    samples_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles == 0) return;
    in_valid <= 1'b0;
    in_item  <= random_sample();
    repeat (cycles) @(posedge clk);
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (expected_drive_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_regs(input logic [31:0] kp, ki, kd, c);
    logic [31:0] vals[4];
    vals[0] = kp;
    vals[1] = ki;
    vals[2] = kd;
    vals[3] = c;
    cfg_valid <= 1'b1;
    for (int i = 0; i < 4; i++) begin
      cfg_index <= ptc_pkg::cfg_idx_e'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    kp_gain = $signed(kp);
    ki_gain = $signed(ki);
    kd_gain = $signed(kd);
    half_period_q = c;
    settings_count++;
  endtask

  task automatic test_reset_defaults();
    stall_enable <= 1'b1;
    send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF));
    send_sample(make_sample(32'h0, 32'h0, 32'h0, 32'h0));
    finish_phase();
  endtask

  // Error clamping alone must not raise clipped; the summed drive may
  task automatic test_error_clamp();
    program_regs(32'h0001_0000, 32'h0, 32'h0001_0000, ptc_pkg::HALF_PERIOD_RST);
    send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0));
    send_sample(make_sample(32'h0, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000));
    send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0));
    send_sample(make_sample(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF));
    send_sample(make_sample(32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001));
    send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000));
    finish_phase();
  endtask

  task automatic test_output_clamp();
    program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
    send_sample(make_sample(32'h0001_0000, 32'h0, 32'h0, 32'h0));
    send_sample(make_sample(32'h0010_0000, 32'h0, 32'h0, 32'h0));
    send_sample(make_sample(32'h0, 32'h0, 32'h0010_0000, 32'h0));
    send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000));
    finish_phase();
  endtask

  // Half-way cases of both roundings: output sum and integrator increment
  task automatic test_rounding_ties();
    program_regs(32'h0000_0001, 32'h0, 32'h0, 32'h8000_0000);
    send_sample(make_sample(32'h0000_8000, 32'h0, 32'h0, 32'h0));
    send_sample(make_sample(32'hFFFF_8000, 32'h0, 32'h0, 32'h0));
    send_sample(make_sample(32'h0000_7FFF, 32'h0, 32'h0, 32'h0));
    send_sample(make_sample(32'hFFFF_7FFF, 32'h0, 32'h0, 32'h0));
    finish_phase();
    program_regs(32'h0, 32'h0000_0001, 32'h0, 32'h8000_0000);
    send_sample(make_sample(32'h0000_8002, 32'h0, 32'h0, 32'h0));
    send_sample(make_sample(32'hFFFF_7FFD, 32'h0, 32'h0, 32'h0));
    finish_phase();
  endtask

  task automatic test_random_mix();
    int unsigned sent, burst;
    value_span_e span;
    logic [31:0] c;
    for (int p = 0; p < 8; p++) begin
      span = (p % 4 == 1) ? SPAN_FULL : (p % 4 == 2) ? SPAN_EXTREME : SPAN_SMALL;
      if (p == 2)          c = 32'h0;
      else if (p == 6)     c = 32'hFFFF_FFFF;
      else if (p % 4 == 3) c = ptc_pkg::HALF_PERIOD_RST;
      else                 c = $urandom;
      program_regs(rand_word(span), rand_word(span), rand_word(span), c);
      stall_enable <= (p != 3);
      sent = 0;
      while (sent < 140) begin
        burst = $urandom_range(1, 8);
        for (int b = 0; b < burst && sent < 140; b++) begin
          send_sample(random_sample());
          sent++;
        end
        if ($urandom_range(0, 24) == 0) finish_phase();
        else pause_sender($urandom_range(0, 12));
      end
      finish_phase();
    end
  endtask

  // Full-scale error at the largest coefficient winds the integrator up by
  // the biggest step it takes, then the opposite error winds it back down
  task automatic test_integrator_windup();
    stall_enable <= 1'b0;
    program_regs(32'h0, 32'h0000_0001, 32'h0, 32'hFFFF_FFFF);
    for (int n = 0; n < 32; n++)
      send_sample(make_sample(32'h7FFF_FFFF, 32'h8000_0000,
                              rand_word(SPAN_SMALL), rand_word(SPAN_SMALL)));
    for (int n = 0; n < 32; n++)
      send_sample(make_sample(32'h8000_0000, 32'h7FFF_FFFF,
                              rand_word(SPAN_SMALL), rand_word(SPAN_SMALL)));
    repeat (4) send_sample(random_sample());
    finish_phase();
  endtask

  // Receiver stalls on a rotating 16-bit pattern, reloaded every lap
  always @(posedge clk) begin
    stall_phase <= stall_phase + 4'd1;
    if (stall_phase == 4'd15) begin
      if ($urandom_range(0, 3) == 0) stall_pattern <= 16'hFFFF;
      else stall_pattern <= 16'($urandom) | 16'h0001;
    end
    out_ready <= !stall_enable || stall_pattern[stall_phase];
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_drive_q.size() == 0) begin
        report_mismatch($sformatf("result with none expected: drive %h clipped %b",
                                  out_item.drive, out_item.clipped));
      end else begin
        oldest_expected = expected_drive_q.pop_front();
        if (out_item.drive !== oldest_expected.drive)
          report_mismatch($sformatf("result %0d drive %h, expected %h", results_seen,
                                    out_item.drive, oldest_expected.drive));
        if (out_item.clipped !== oldest_expected.clipped)
          report_mismatch($sformatf("result %0d clipped %b, expected %b", results_seen,
                                    out_item.clipped, oldest_expected.clipped));
        results_seen++;
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_error_clamp();
    test_output_clamp();
    test_rounding_ties();
    test_random_mix();
    test_integrator_windup();
    repeat (16) @(posedge clk);
    if (expected_drive_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_drive_q.size()));
    $display("Sent %0d samples, checked %0d results over %0d register settings",
             samples_sent, results_seen, settings_count);
    $display("Run took in clamping, rounding ties, stalls and full-scale wind-up;"
             , " %0d mismatches", mismatches);
    if (mismatches == 0) begin
      $display("pid_trapezoid_controller_top test passed");
    end else begin
      $display("pid_trapezoid_controller_top test failed");
    end
    $finish;
  end

  initial begin
    #(2_000_000);
    $display("Timeout with %0d results outstanding", expected_drive_q.size());
    $display("pid_trapezoid_controller_top test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
design/ptc_pkg.sv
design/ptc_mul.sv
design/ptc_seq.sv
design/pid_trapezoid_controller_top.sv
bench/pid_trapezoid_controller_top_test.sv
